@@ rtl/sync_word_frame_receiver_macros.svh @@
// assertion macros shared by the rtl
`ifndef SYNC_WORD_FRAME_RECEIVER_MACROS_SVH
`define SYNC_WORD_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, off while reset is held
`define SWFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swfr implication check failed");

// next-cycle implication, off while reset is held
`define SWFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swfr next-cycle check failed");

`endif

@@ rtl/swfr_pkg.sv @@
`default_nettype none

package swfr_pkg;

  // sync pair and header layout
  localparam logic [7:0] SYNC_FIRST  = 8'h53;
  localparam logic [7:0] SYNC_SECOND = 8'h43;
  localparam int         HDR_IDX_W   = 3;
  localparam logic [HDR_IDX_W-1:0] HDR_TGT_LO = 3'd0;
  localparam logic [HDR_IDX_W-1:0] HDR_TGT_HI = 3'd1;
  localparam logic [HDR_IDX_W-1:0] HDR_SRC_LO = 3'd2;
  localparam logic [HDR_IDX_W-1:0] HDR_SRC_HI = 3'd3;
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO = 3'd4;
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI = 3'd5;

  // configuration port
  localparam int              CFG_IDX_W = 8;
  localparam int              CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BCAST_ID  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_KIND = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 8'd3;

  // port kinds
  localparam logic [1:0] PK_SECURITY = 2'd0;
  localparam logic [1:0] PK_HOST     = 2'd1;
  localparam logic [1:0] PK_RADIO    = 2'd2;
  localparam logic [1:0] PK_UNKNOWN  = 2'd3;

  // register reset values
  localparam logic [15:0] OWN_ID_RST    = 16'd0;
  localparam logic [15:0] BCAST_ID_RST  = 16'd0;
  localparam logic [1:0]  PORT_KIND_RST = PK_HOST;
  localparam logic [15:0] CAPACITY_RST  = 16'd16384;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SYNC,
    PH_HEADER,
    PH_BODY
  } phase_t;

  typedef struct packed {
    logic [15:0] own_id;
    logic [15:0] broadcast_id;
    logic [1:0]  port_kind;
    logic [15:0] capacity;
  } cfg_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic        accepted;
    logic [15:0] source_id;
    logic [15:0] target_id;
    logic [15:0] kept_length;
  } res_t;

  // per-interface address filter, true means accept
  function automatic logic filter_pass(cfg_t cfg, logic [15:0] src, logic [15:0] tgt);
    logic pass;
    pass = 1'b0;
    unique case (cfg.port_kind)
      PK_SECURITY: pass = 1'b1;
      PK_HOST:     pass = (src == cfg.own_id) && (tgt != cfg.own_id);
      PK_RADIO:    pass = (src != cfg.own_id) && (src != cfg.broadcast_id) &&
                          ((tgt == cfg.broadcast_id) || (tgt == cfg.own_id));
      PK_UNKNOWN:  pass = 1'b0;
      default:     pass = 1'b0;
    endcase
    return pass;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sync_word_frame_receiver.sv @@
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_rx_byte
// out     | output    | out_valid / out_ready | out_payload_valid .. out_kept_length
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one word per cycle while in_ready is high: the parser decides each word in the cycle it is taken
// and its result lands in the output register, or in the skid entry when that register is held, on the next edge
// a two-entry output stage (register plus skid) lets in_ready stay high
// while one result waits; in_ready drops only when both entries are full
// rst_n is synchronous: hunting for the first sync byte, no result pending,
// registers at their defaults; cfg_ready is always high
`default_nettype none

module sync_word_frame_receiver (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_payload_valid,
  output logic [7:0]                          out_payload_byte,
  output logic                                out_frame_end,
  output logic                                out_accepted,
  output logic [15:0]                         out_source_id,
  output logic [15:0]                         out_target_id,
  output logic [15:0]                         out_kept_length,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [swfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [swfr_pkg::CFG_DAT_W-1:0] cfg_data
);

  swfr_pkg::cfg_t cfg;
  swfr_pkg::res_t res;
  swfr_pkg::res_t out_res;
  logic           res_valid;
  logic           accept;

  assign accept = in_valid && in_ready;

  // configuration registers
  swfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // frame parser
  swfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register with skid
  swfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .push      (res_valid),
    .push_res  (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_payload_valid = out_res.payload_valid;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_frame_end     = out_res.frame_end;
  assign out_accepted      = out_res.accepted;
  assign out_source_id     = out_res.source_id;
  assign out_target_id     = out_res.target_id;
  assign out_kept_length   = out_res.kept_length;

endmodule

`default_nettype wire

@@ rtl/swfr_cfg_regs.sv @@
`default_nettype none

module swfr_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [swfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [swfr_pkg::CFG_DAT_W-1:0] cfg_data,
  output swfr_pkg::cfg_t                      cfg
);

  swfr_pkg::cfg_t cfg_r;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register file, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_id       <= swfr_pkg::OWN_ID_RST;
      cfg_r.broadcast_id <= swfr_pkg::BCAST_ID_RST;
      cfg_r.port_kind    <= swfr_pkg::PORT_KIND_RST;
      cfg_r.capacity     <= swfr_pkg::CAPACITY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        swfr_pkg::REG_OWN_ID:    cfg_r.own_id       <= cfg_data;
        swfr_pkg::REG_BCAST_ID:  cfg_r.broadcast_id <= cfg_data;
        swfr_pkg::REG_PORT_KIND: cfg_r.port_kind    <= cfg_data[1:0];
        swfr_pkg::REG_CAPACITY:  cfg_r.capacity     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/swfr_parser.sv @@
`default_nettype none

module swfr_parser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept,
  input  wire logic [7:0]     rx_byte,
  input  swfr_pkg::cfg_t      cfg,
  output logic                res_valid,
  output swfr_pkg::res_t      res
);

`include "sync_word_frame_receiver_macros.svh"

  swfr_pkg::phase_t                 phase_r, phase_nxt;
  logic [swfr_pkg::HDR_IDX_W-1:0]   idx_r, idx_nxt;
  logic [15:0]                      tgt_r, tgt_nxt;
  logic [15:0]                      src_r, src_nxt;
  logic [15:0]                      len_r, len_nxt;
  logic [15:0]                      cnt_r, cnt_nxt;
  logic [15:0]                      kept_r, kept_nxt;
  logic                             passes_r, passes_nxt;

  logic [15:0] len_full;
  logic [16:0] cnt_inc;
  logic        emit;
  logic        last;

  // full length as the last header byte arrives
  assign len_full = {rx_byte, len_r[7:0]};
  assign cnt_inc  = {1'b0, cnt_r} + 17'd1;
  assign emit     = passes_r && (cnt_r < kept_r);
  assign last     = cnt_inc >= {1'b0, len_r};

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= swfr_pkg::PH_HUNT;
      idx_r    <= '0;
      passes_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      passes_r <= passes_nxt;
    end
  end

  // header fields and body counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r  <= '0;
      src_r  <= '0;
      len_r  <= '0;
      cnt_r  <= '0;
      kept_r <= '0;
    end else begin
      tgt_r  <= tgt_nxt;
      src_r  <= src_nxt;
      len_r  <= len_nxt;
      cnt_r  <= cnt_nxt;
      kept_r <= kept_nxt;
    end
  end

  // next state and result for one word
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    tgt_nxt    = tgt_r;
    src_nxt    = src_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    kept_nxt   = kept_r;
    passes_nxt = passes_r;
    res_valid  = 1'b0;
    res        = '0;
    if (accept) begin
      unique case (phase_r)
        swfr_pkg::PH_HUNT: begin
          if (rx_byte == swfr_pkg::SYNC_FIRST) phase_nxt = swfr_pkg::PH_SYNC;
        end
        swfr_pkg::PH_SYNC: begin
          if (rx_byte == swfr_pkg::SYNC_SECOND) begin
            phase_nxt = swfr_pkg::PH_HEADER;
            idx_nxt   = '0;
          end else if (rx_byte != swfr_pkg::SYNC_FIRST) begin
            phase_nxt = swfr_pkg::PH_HUNT;
          end
        end
        swfr_pkg::PH_HEADER: begin
          idx_nxt = idx_r + 3'd1;
          unique case (idx_r)
            swfr_pkg::HDR_TGT_LO: tgt_nxt = {8'h00, rx_byte};
            swfr_pkg::HDR_TGT_HI: tgt_nxt = {rx_byte, tgt_r[7:0]};
            swfr_pkg::HDR_SRC_LO: src_nxt = {8'h00, rx_byte};
            swfr_pkg::HDR_SRC_HI: src_nxt = {rx_byte, src_r[7:0]};
            swfr_pkg::HDR_LEN_LO: len_nxt = {8'h00, rx_byte};
            default: begin
              // last header byte: settle filter and kept length
              len_nxt    = len_full;
              idx_nxt    = '0;
              cnt_nxt    = '0;
              passes_nxt = swfr_pkg::filter_pass(cfg, src_r, tgt_r);
              kept_nxt   = (len_full < cfg.capacity) ? len_full : cfg.capacity;
              if (len_full == 16'd0) begin
                phase_nxt       = swfr_pkg::PH_HUNT;
                res_valid       = 1'b1;
                res.frame_end   = 1'b1;
                res.accepted    = passes_nxt;
                res.source_id   = src_r;
                res.target_id   = tgt_r;
                res.kept_length = kept_nxt;
              end else begin
                phase_nxt = swfr_pkg::PH_BODY;
              end
            end
          endcase
        end
        swfr_pkg::PH_BODY: begin
          cnt_nxt = cnt_inc[15:0];
          if (emit) begin
            res_valid         = 1'b1;
            res.payload_valid = 1'b1;
            res.payload_byte  = rx_byte;
          end
          if (last) begin
            phase_nxt       = swfr_pkg::PH_HUNT;
            res_valid       = 1'b1;
            res.frame_end   = 1'b1;
            res.accepted    = passes_r;
            res.source_id   = src_r;
            res.target_id   = tgt_r;
            res.kept_length = kept_r;
          end
        end
        default: phase_nxt = swfr_pkg::PH_HUNT;
      endcase
    end
  end

  // header index never runs past the length high byte
  `SWFR_ASSERT_IMP(a_hdr_idx, clk, rst_n, phase_r == swfr_pkg::PH_HEADER,
                   idx_r <= swfr_pkg::HDR_LEN_HI)
  // body words only leave for a passing frame within its kept length
  `SWFR_ASSERT_IMP(a_emit_body, clk, rst_n, res_valid && res.payload_valid,
                   phase_r == swfr_pkg::PH_BODY && passes_r && cnt_r < kept_r)

endmodule

`default_nettype wire

@@ rtl/swfr_out_stage.sv @@
`default_nettype none

module swfr_out_stage (
  input  wire logic      clk,
  input  wire logic      rst_n,
  output logic           in_ready,
  input  wire logic      push,
  input  swfr_pkg::res_t push_res,
  output logic           out_valid,
  input  wire logic      out_ready,
  output swfr_pkg::res_t out_res
);

`include "sync_word_frame_receiver_macros.svh"

  logic           main_valid_r;
  logic           skid_valid_r;
  swfr_pkg::res_t main_r;
  swfr_pkg::res_t skid_r;
  logic           pop;

  // upstream only stalls when the skid slot is taken
  assign in_ready  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;
  assign pop       = main_valid_r && out_ready;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) skid_valid_r <= 1'b0;
    end else if (push) begin
      if (main_valid_r && !pop) skid_valid_r <= 1'b1;
      main_valid_r <= 1'b1;
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  // result words
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) main_r <= skid_r;
    end else if (push) begin
      if (main_valid_r && !pop) skid_r <= push_res;
      else main_r <= push_res;
    end
  end

  // a held skid word means the output is full
  `SWFR_ASSERT_IMP(a_skid_main, clk, rst_n, skid_valid_r, main_valid_r)
  // a stalled full stage keeps its spare word
  `SWFR_ASSERT_NXT(a_skid_hold, clk, rst_n, skid_valid_r && !out_ready, skid_valid_r)
  // no word is taken while the stage is full
  `SWFR_ASSERT_IMP(a_no_push_full, clk, rst_n, skid_valid_r, !push)

endmodule

`default_nettype wire
